// ===== rtl/core/plrc_pkg.sv =====
package plrc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_CMP,
        ST_MULA,
        ST_MULB,
        ST_APPLY,
        ST_LGO,
        ST_LMUL,
        ST_LDIV,
        ST_LFIN,
        ST_OUT0,
        ST_OUT1
    } state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_cmd_t;

    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_TOP    = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam logic [15:0] RESET_LEFT   = 16'd0;
    localparam logic [15:0] RESET_TOP    = 16'd0;
    localparam logic [14:0] RESET_WIDTH  = 15'd320;
    localparam logic [14:0] RESET_HEIGHT = 15'd240;

endpackage

// ===== rtl/core/plrc_muldiv.sv =====
module plrc_muldiv #(
    parameter int M = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  plrc_pkg::md_cmd_t  cmd,
    input  logic [2*M-1:0]     x,
    input  logic [M-1:0]       y,
    output logic               done,
    output logic [M-1:0]       hi,
    output logic [2*M-1:0]     lo
);

    localparam int CNT_BITS = $clog2(2*M + 1);
    localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(M - 1);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(2*M - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                div_reg, div_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [M-1:0]        h_reg, h_next;
    logic [2*M-1:0]      w_reg, w_next;
    logic [M-1:0]        d_reg, d_next;

    logic [M:0] sum;
    logic [M:0] r2;
    logic [M:0] diff;
    logic       ge;

    // Multiply shifts the multiplier out of the low half of w while the
    // product grows into h; divide shifts the dividend out of the top of w
    // and the quotient bits in at the bottom.
    always_comb
    begin
        sum  = {1'b0, h_reg} + (w_reg[0] ? {1'b0, d_reg} : '0);
        r2   = {h_reg, w_reg[2*M-1]};
        ge   = (r2 >= {1'b0, d_reg});
        diff = r2 - {1'b0, d_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        h_next    = h_reg;
        w_next    = w_reg;
        d_next    = d_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            div_next  = cmd.is_div;
            cnt_next  = '0;
            h_next    = '0;
            w_next    = x;
            d_next    = y;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                h_next = ge ? diff[M-1:0] : r2[M-1:0];
                w_next = {w_reg[2*M-2:0], ge};
            end
            else
            begin
                h_next = sum[M:1];
                w_next = {w_reg[2*M-1:M], sum[0], w_reg[M-1:1]};
            end
            if (cnt_reg == (div_reg ? DIV_LAST : MUL_LAST))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        w_reg <= w_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign hi   = h_reg;
    assign lo   = w_reg;

endmodule

// ===== rtl/core/polyline_rect_clipper.sv =====
// Polyline clipper against an inclusive rectangle.
// Vertices arrive on the input channel (in_valid/in_ready) one transaction
// each. Every vertex after the first of a series forms a segment with the
// previous one; a visible segment gives one or two clipped vertices on the
// output channel (out_valid/out_ready), the last flagged with last. A vertex
// that forms no visible segment produces no output transaction.
// The rectangle is set through the cfg channel (cfg_index, cfg_data), which
// is always ready; write it only while the block is idle.
// One item is processed at a time: in_ready is high only while idle. All
// ratio compares and interpolations run through one serial multiply/divide
// unit of M = max(COORD_BITS,17)+1 bits. A segment costs up to eight
// compares of two multiplies each plus four interpolations of one multiply
// and one divide.
// Results are held in registers and shown until taken; a stalled receiver
// simply holds the block in its output states.
// Reset clears the stored vertex and run flag and loads the default
// rectangle (0, 0, 320, 240).
module polyline_rect_clipper #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         gap,
    input  logic                         series_start,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic                         run_begin,
    output logic                         last
);

    localparam int CW  = COORD_BITS;
    localparam int EXT = (COORD_BITS > 17) ? COORD_BITS : 17;
    localparam int W   = EXT + 2;
    localparam int M   = W - 1;

    plrc_pkg::state_t state_reg, state_next;

    logic signed [15:0] clip_left_reg, clip_left_next;
    logic signed [15:0] clip_top_reg, clip_top_next;
    logic [14:0]        clip_width_reg, clip_width_next;
    logic [14:0]        clip_height_reg, clip_height_next;

    logic signed [CW-1:0] prev_x_reg, prev_x_next;
    logic signed [CW-1:0] prev_y_reg, prev_y_next;
    logic                 have_prev_reg, have_prev_next;
    logic                 in_run_reg, in_run_next;
    logic                 beg_reg, beg_next;
    logic [1:0]           edge_reg, edge_next;
    logic                 cidx_reg, cidx_next;
    logic [1:0]           li_reg, li_next;

    logic signed [CW-1:0] cur_x_reg, cur_x_next;
    logic signed [CW-1:0] cur_y_reg, cur_y_next;
    logic                 pneg_reg, pneg_next;
    logic signed [W-1:0]  rn_reg, rn_next;
    logic [M-1:0]         rd_reg, rd_next;
    logic [M-1:0]         t0n_reg, t0n_next, t0d_reg, t0d_next;
    logic [M-1:0]         t1n_reg, t1n_next, t1d_reg, t1d_next;
    logic [2*M-1:0]       proda_reg, proda_next;
    logic                 lt_reg, lt_next, gt_reg, gt_next;
    logic signed [CW-1:0] r0x_reg, r0x_next, r0y_reg, r0y_next;
    logic signed [CW-1:0] r1x_reg, r1x_next, r1y_reg, r1y_next;

    plrc_pkg::md_cmd_t md_cmd;
    logic [2*M-1:0]    md_x;
    logic [M-1:0]      md_y;
    logic              md_done;
    logic [M-1:0]      md_hi;
    logic [2*M-1:0]    md_lo;
    logic [2*M-1:0]    md_prod;

    plrc_muldiv #(
        .M(M)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (md_cmd),
        .x     (md_x),
        .y     (md_y),
        .done  (md_done),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    assign md_prod = {md_hi, md_lo[M-1:0]};

    // Segment geometry, all in W-bit signed arithmetic.
    logic signed [W-1:0] px_w, py_w, cx_w, cy_w, dx_w, dy_w;
    logic signed [W-1:0] left_w, right_w, top_w, bottom_w;
    logic signed [W-1:0] p_w, q_w, rn_w, pmag_w, neg_p_w;
    logic                p_zero, p_neg;

    // Compare helpers.
    logic         sel_t1;
    logic [M-1:0] tn, td;
    logic         tpos;
    logic         cond;

    // Interpolation helpers.
    logic signed [CW-1:0] a_c;
    logic signed [W-1:0]  delta_w, dmag_w;
    logic [M-1:0]         ltn, ltd;
    logic [CW:0]          qm;
    logic [M-1:0]         rm, rem;
    logic signed [CW+1:0] qm_s, q_s, base_s, res_s;
    logic [M:0]           rem2;
    logic                 inc;

    always_comb
    begin
        px_w     = W'(prev_x_reg);
        py_w     = W'(prev_y_reg);
        cx_w     = W'(cur_x_reg);
        cy_w     = W'(cur_y_reg);
        dx_w     = cx_w - px_w;
        dy_w     = cy_w - py_w;
        left_w   = W'(clip_left_reg);
        top_w    = W'(clip_top_reg);
        right_w  = left_w + W'($signed({1'b0, clip_width_reg}));
        bottom_w = top_w + W'($signed({1'b0, clip_height_reg}));

        case (edge_reg)
            2'd0:
            begin
                p_w = -dx_w;
                q_w = px_w - left_w;
            end
            2'd1:
            begin
                p_w = dx_w;
                q_w = right_w - px_w;
            end
            2'd2:
            begin
                p_w = -dy_w;
                q_w = py_w - top_w;
            end
            default:
            begin
                p_w = dy_w;
                q_w = bottom_w - py_w;
            end
        endcase

        p_zero  = (p_w == '0);
        p_neg   = p_w[W-1];
        neg_p_w = -p_w;
        rn_w    = p_neg ? -q_w : q_w;
        pmag_w  = p_neg ? neg_p_w : p_w;

        sel_t1 = pneg_reg ^ cidx_reg;
        tn     = sel_t1 ? t1n_reg : t0n_reg;
        td     = sel_t1 ? t1d_reg : t0d_reg;
        tpos   = (tn != '0);
        cond   = pneg_reg ? gt_reg : lt_reg;

        a_c     = li_reg[0] ? prev_y_reg : prev_x_reg;
        delta_w = li_reg[0] ? dy_w : dx_w;
        dmag_w  = delta_w[W-1] ? -delta_w : delta_w;
        ltn     = li_reg[1] ? t1n_reg : t0n_reg;
        ltd     = li_reg[1] ? t1d_reg : t0d_reg;

        // Round half away from zero: floor the signed quotient, then bump
        // by one when the fractional part reaches one half (strictly more
        // than one half for a negative base).
        qm   = md_lo[CW:0];
        rm   = md_hi;
        qm_s = $signed({1'b0, qm});
        if (!delta_w[W-1])
        begin
            q_s = qm_s;
            rem = rm;
        end
        else if (rm == '0)
        begin
            q_s = -qm_s;
            rem = '0;
        end
        else
        begin
            q_s = -qm_s - (CW+2)'(1);
            rem = ltd - rm;
        end
        base_s = (CW+2)'(a_c) + q_s;
        rem2   = {rem, 1'b0};
        inc    = base_s[CW+1] ? (rem2 > {1'b0, ltd}) : (rem2 >= {1'b0, ltd});
        res_s  = base_s + (CW+2)'(inc);
    end

    always_comb
    begin
        state_next       = state_reg;
        clip_left_next   = clip_left_reg;
        clip_top_next    = clip_top_reg;
        clip_width_next  = clip_width_reg;
        clip_height_next = clip_height_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        have_prev_next   = have_prev_reg;
        in_run_next      = in_run_reg;
        beg_next         = beg_reg;
        edge_next        = edge_reg;
        cidx_next        = cidx_reg;
        li_next          = li_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        pneg_next        = pneg_reg;
        rn_next          = rn_reg;
        rd_next          = rd_reg;
        t0n_next         = t0n_reg;
        t0d_next         = t0d_reg;
        t1n_next         = t1n_reg;
        t1d_next         = t1d_reg;
        proda_next       = proda_reg;
        lt_next          = lt_reg;
        gt_next          = gt_reg;
        r0x_next         = r0x_reg;
        r0y_next         = r0y_reg;
        r1x_next         = r1x_reg;
        r1y_next         = r1y_reg;

        md_cmd    = '0;
        md_x      = '0;
        md_y      = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        out_x     = r1x_reg;
        out_y     = r1y_reg;
        run_begin = 1'b0;
        last      = 1'b0;
        cfg_ready = 1'b1;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                plrc_pkg::CFG_LEFT:   clip_left_next   = cfg_data;
                plrc_pkg::CFG_TOP:    clip_top_next    = cfg_data;
                plrc_pkg::CFG_WIDTH:  clip_width_next  = cfg_data[14:0];
                plrc_pkg::CFG_HEIGHT: clip_height_next = cfg_data[14:0];
                default:              clip_left_next   = clip_left_reg;
            endcase
        end

        unique case (state_reg)
            plrc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (gap)
                    begin
                        have_prev_next = 1'b0;
                        in_run_next    = 1'b0;
                    end
                    else if (series_start || !have_prev_reg)
                    begin
                        prev_x_next    = point_x;
                        prev_y_next    = point_y;
                        have_prev_next = 1'b1;
                        in_run_next    = series_start ? 1'b0 : in_run_reg;
                    end
                    else
                    begin
                        cur_x_next = point_x;
                        cur_y_next = point_y;
                        t0n_next   = '0;
                        t0d_next   = M'(1);
                        t1n_next   = M'(1);
                        t1d_next   = M'(1);
                        edge_next  = 2'd0;
                        state_next = plrc_pkg::ST_EDGE;
                    end
                end
            end

            plrc_pkg::ST_EDGE:
            begin
                if (p_zero)
                begin
                    if (q_w[W-1])
                    begin
                        in_run_next = 1'b0;
                        prev_x_next = cur_x_reg;
                        prev_y_next = cur_y_reg;
                        state_next  = plrc_pkg::ST_IDLE;
                    end
                    else if (edge_reg == 2'd3)
                    begin
                        beg_next    = !in_run_reg;
                        li_next     = in_run_reg ? 2'd2 : 2'd0;
                        in_run_next = 1'b1;
                        state_next  = plrc_pkg::ST_LGO;
                    end
                    else
                    begin
                        edge_next = edge_reg + 2'd1;
                    end
                end
                else
                begin
                    rn_next    = rn_w;
                    rd_next    = pmag_w[M-1:0];
                    pneg_next  = p_neg;
                    cidx_next  = 1'b0;
                    state_next = plrc_pkg::ST_CMP;
                end
            end

            plrc_pkg::ST_CMP:
            begin
                // Signs settle most compares; only two positive ratios
                // need the cross products.
                if (rn_reg[W-1])
                begin
                    lt_next    = 1'b1;
                    gt_next    = 1'b0;
                    state_next = plrc_pkg::ST_APPLY;
                end
                else if (rn_reg == '0)
                begin
                    lt_next    = tpos;
                    gt_next    = 1'b0;
                    state_next = plrc_pkg::ST_APPLY;
                end
                else if (!tpos)
                begin
                    lt_next    = 1'b0;
                    gt_next    = 1'b1;
                    state_next = plrc_pkg::ST_APPLY;
                end
                else
                begin
                    md_cmd.start = 1'b1;
                    md_x         = (2*M)'(rn_reg[M-1:0]);
                    md_y         = td;
                    state_next   = plrc_pkg::ST_MULA;
                end
            end

            plrc_pkg::ST_MULA:
            begin
                if (md_done)
                begin
                    proda_next   = md_prod;
                    md_cmd.start = 1'b1;
                    md_x         = (2*M)'(tn);
                    md_y         = rd_reg;
                    state_next   = plrc_pkg::ST_MULB;
                end
            end

            plrc_pkg::ST_MULB:
            begin
                if (md_done)
                begin
                    lt_next    = (proda_reg < md_prod);
                    gt_next    = (proda_reg > md_prod);
                    state_next = plrc_pkg::ST_APPLY;
                end
            end

            plrc_pkg::ST_APPLY:
            begin
                if (!cidx_reg)
                begin
                    if (cond)
                    begin
                        in_run_next = 1'b0;
                        prev_x_next = cur_x_reg;
                        prev_y_next = cur_y_reg;
                        state_next  = plrc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cidx_next  = 1'b1;
                        state_next = plrc_pkg::ST_CMP;
                    end
                end
                else
                begin
                    if (cond)
                    begin
                        if (pneg_reg)
                        begin
                            t0n_next = rn_reg[M-1:0];
                            t0d_next = rd_reg;
                        end
                        else
                        begin
                            t1n_next = rn_reg[M-1:0];
                            t1d_next = rd_reg;
                        end
                    end
                    if (edge_reg == 2'd3)
                    begin
                        beg_next    = !in_run_reg;
                        li_next     = in_run_reg ? 2'd2 : 2'd0;
                        in_run_next = 1'b1;
                        state_next  = plrc_pkg::ST_LGO;
                    end
                    else
                    begin
                        edge_next  = edge_reg + 2'd1;
                        state_next = plrc_pkg::ST_EDGE;
                    end
                end
            end

            plrc_pkg::ST_LGO:
            begin
                md_cmd.start = 1'b1;
                md_x         = (2*M)'(ltn);
                md_y         = dmag_w[M-1:0];
                state_next   = plrc_pkg::ST_LMUL;
            end

            plrc_pkg::ST_LMUL:
            begin
                if (md_done)
                begin
                    md_cmd.start  = 1'b1;
                    md_cmd.is_div = 1'b1;
                    md_x          = md_prod;
                    md_y          = ltd;
                    state_next    = plrc_pkg::ST_LDIV;
                end
            end

            plrc_pkg::ST_LDIV:
            begin
                if (md_done)
                begin
                    state_next = plrc_pkg::ST_LFIN;
                end
            end

            plrc_pkg::ST_LFIN:
            begin
                case (li_reg)
                    2'd0:    r0x_next = res_s[CW-1:0];
                    2'd1:    r0y_next = res_s[CW-1:0];
                    2'd2:    r1x_next = res_s[CW-1:0];
                    default: r1y_next = res_s[CW-1:0];
                endcase
                if (li_reg == 2'd3)
                begin
                    prev_x_next = cur_x_reg;
                    prev_y_next = cur_y_reg;
                    state_next  = beg_reg ? plrc_pkg::ST_OUT0 : plrc_pkg::ST_OUT1;
                end
                else
                begin
                    li_next    = li_reg + 2'd1;
                    state_next = plrc_pkg::ST_LGO;
                end
            end

            plrc_pkg::ST_OUT0:
            begin
                out_valid = 1'b1;
                out_x     = r0x_reg;
                out_y     = r0y_reg;
                run_begin = 1'b1;
                if (out_ready)
                begin
                    state_next = plrc_pkg::ST_OUT1;
                end
            end

            plrc_pkg::ST_OUT1:
            begin
                out_valid = 1'b1;
                last      = 1'b1;
                if (out_ready)
                begin
                    state_next = plrc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = plrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= plrc_pkg::ST_IDLE;
            clip_left_reg   <= plrc_pkg::RESET_LEFT;
            clip_top_reg    <= plrc_pkg::RESET_TOP;
            clip_width_reg  <= plrc_pkg::RESET_WIDTH;
            clip_height_reg <= plrc_pkg::RESET_HEIGHT;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            have_prev_reg   <= 1'b0;
            in_run_reg      <= 1'b0;
            beg_reg         <= 1'b0;
            edge_reg        <= '0;
            cidx_reg        <= 1'b0;
            li_reg          <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clip_left_reg   <= clip_left_next;
            clip_top_reg    <= clip_top_next;
            clip_width_reg  <= clip_width_next;
            clip_height_reg <= clip_height_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            have_prev_reg   <= have_prev_next;
            in_run_reg      <= in_run_next;
            beg_reg         <= beg_next;
            edge_reg        <= edge_next;
            cidx_reg        <= cidx_next;
            li_reg          <= li_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        pneg_reg  <= pneg_next;
        rn_reg    <= rn_next;
        rd_reg    <= rd_next;
        t0n_reg   <= t0n_next;
        t0d_reg   <= t0d_next;
        t1n_reg   <= t1n_next;
        t1d_reg   <= t1d_next;
        proda_reg <= proda_next;
        lt_reg    <= lt_next;
        gt_reg    <= gt_next;
        r0x_reg   <= r0x_next;
        r0y_reg   <= r0y_next;
        r1x_reg   <= r1x_next;
        r1y_reg   <= r1y_next;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CB          = 24;
    localparam int SETTLE      = 800;   // worst case segment latency with margin
    localparam int WDOG_LIMIT  = 6000;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct {
        coord_t x;
        coord_t y;
        bit     rb;
        bit     lst;
    } vertex_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         in_valid;
    logic         in_ready;
    coord_t       point_x;
    coord_t       point_y;
    logic         gap;
    logic         series_start;
    logic         out_valid;
    logic         out_ready;
    coord_t       out_x;
    coord_t       out_y;
    logic         run_begin;
    logic         last;

    polyline_rect_clipper #(.COORD_BITS(CB)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .gap          (gap),
        .series_start (series_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .run_begin    (run_begin),
        .last         (last)
    );

    // Clipper state mirrored by the predictor.
    longint  rect_left, rect_top, rect_w, rect_h;
    longint  last_x, last_y;
    bit      have_last, run_open;

    vertex_t clipped_q[$];
    vertex_t want;
    int      err_cnt;
    int      idle_cnt;
    bit      no_stall;
    bit      hold_req;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int ratio_cmp(longint an, longint ad, longint bn, longint bd);
        longint l, r;
        l = an * bd;
        r = bn * ad;
        return (l > r) ? 1 : ((l < r) ? -1 : 0);
    endfunction

    function automatic bit edge_pass(longint p, longint q, inout longint t0n, inout longint t0d,
                                     inout longint t1n, inout longint t1d);
        longint rn, rd;
        if (p == 0)
            return q >= 0;
        if (p < 0)
        begin
            rn = -q;
            rd = -p;
            if (ratio_cmp(rn, rd, t1n, t1d) > 0)
                return 1'b0;
            if (ratio_cmp(rn, rd, t0n, t0d) > 0)
            begin
                t0n = rn;
                t0d = rd;
            end
        end
        else
        begin
            rn = q;
            rd = p;
            if (ratio_cmp(rn, rd, t0n, t0d) < 0)
                return 1'b0;
            if (ratio_cmp(rn, rd, t1n, t1d) < 0)
            begin
                t1n = rn;
                t1d = rd;
            end
        end
        return 1'b1;
    endfunction

    // a + (tn/td)*delta, rounded half away from zero.
    function automatic coord_t interp(longint a, longint delta, longint tn, longint td);
        longint pr, qm, rm, q, rem, base;
        pr = tn * ((delta < 0) ? -delta : delta);
        qm = pr / td;
        rm = pr % td;
        if (delta >= 0)
        begin
            q = qm;
            rem = rm;
        end
        else if (rm == 0)
        begin
            q = -qm;
            rem = 0;
        end
        else
        begin
            q = -qm - 1;
            rem = td - rm;
        end
        base = a + q;
        if (base >= 0)
        begin
            if (2 * rem >= td)
                base++;
        end
        else if (2 * rem > td)
        begin
            base++;
        end
        return coord_t'(base);
    endfunction

    task automatic clip_segment(coord_t px, coord_t py, bit g, bit ss);
        longint  cx, cy, dx, dy, t0n, t0d, t1n, t1d;
        bit      vis;
        vertex_t v;
        cx = longint'(px);
        cy = longint'(py);
        if (ss)
        begin
            have_last = 1'b0;
            run_open = 1'b0;
        end
        if (g)
        begin
            have_last = 1'b0;
            run_open = 1'b0;
            return;
        end
        if (have_last)
        begin
            dx = cx - last_x;
            dy = cy - last_y;
            t0n = 0; t0d = 1; t1n = 1; t1d = 1;
            vis = edge_pass(-dx, last_x - rect_left, t0n, t0d, t1n, t1d);
            if (vis)
                vis = edge_pass(dx, rect_left + rect_w - last_x, t0n, t0d, t1n, t1d);
            if (vis)
                vis = edge_pass(-dy, last_y - rect_top, t0n, t0d, t1n, t1d);
            if (vis)
                vis = edge_pass(dy, rect_top + rect_h - last_y, t0n, t0d, t1n, t1d);
            if (vis)
            begin
                if (!run_open)
                begin
                    v.x = interp(last_x, dx, t0n, t0d);
                    v.y = interp(last_y, dy, t0n, t0d);
                    v.rb = 1'b1;
                    v.lst = 1'b0;
                    clipped_q = {clipped_q, v};
                    run_open = 1'b1;
                end
                v.x = interp(last_x, dx, t1n, t1d);
                v.y = interp(last_y, dy, t1n, t1d);
                v.rb = 1'b0;
                v.lst = 1'b1;
                clipped_q = {clipped_q, v};
            end
            else
            begin
                run_open = 1'b0;
            end
        end
        last_x = cx;
        last_y = cy;
        have_last = 1'b1;
    endtask

    task automatic send_point(longint px, longint py, bit g, bit ss);
        int n;
        n = no_stall ? 0 : $urandom_range(0, 8);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x <= coord_t'(px);
        point_y <= coord_t'(py);
        gap <= g;
        series_start <= ss;
        do
            @(posedge clk);
        while (!in_ready);
        clip_segment(coord_t'(px), coord_t'(py), g, ss);
    endtask

    // Drops valid at the edge that took the last transaction, so the block
    // never sees it twice.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (clipped_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            plrc_pkg::CFG_LEFT:   rect_left = longint'($signed(data));
            plrc_pkg::CFG_TOP:    rect_top = longint'($signed(data));
            plrc_pkg::CFG_WIDTH:  rect_w = longint'(data[14:0]);
            plrc_pkg::CFG_HEIGHT: rect_h = longint'(data[14:0]);
            default: ;
        endcase
    endtask

    task automatic set_rect(logic [15:0] l, logic [15:0] t, logic [15:0] w, logic [15:0] h);
        wait_idle();
        write_reg(plrc_pkg::CFG_LEFT, l);
        write_reg(plrc_pkg::CFG_TOP, t);
        write_reg(plrc_pkg::CFG_WIDTH, w);
        write_reg(plrc_pkg::CFG_HEIGHT, h);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic longint near_coord(longint lo, longint span);
        return lo - 40 + longint'($urandom_range(0, 32'(span) + 80));
    endfunction

    // Mostly well-formed polylines around the rectangle, with gaps and wild points mixed in.
    task automatic random_points(int count);
        int     k, kind;
        longint px, py;
        for (k = 0; k < count; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 4)
                px = longint'($signed(24'($urandom)));
            else
                px = near_coord(rect_left, rect_w);
            if (kind < 4 || (kind >= 96))
                py = longint'($signed(24'($urandom)));
            else
                py = near_coord(rect_top, rect_h);
            send_point(px, py, kind >= 4 && kind < 7, kind >= 7 && kind < 12 || kind == 3);
        end
    endtask

    task automatic test_directed();
        send_point(10, 10, 0, 1);
        send_point(100, 100, 0, 0);
        send_point(400, 100, 0, 0);      // end clipped, run stays open
        send_point(200, 120, 0, 0);      // comes back inside: end point only
        send_point(160, -100, 0, 0);
        send_point(160, -300, 0, 0);     // fully outside closes the run
        send_point(50, 50, 1, 0);        // gap
        send_point(60, 60, 0, 0);        // no previous vertex
        send_point(70, 70, 1, 1);        // gap together with series start
        send_point(0, 0, 0, 1);
        send_point(0, 0, 0, 0);          // zero length inside
        send_point(320, 240, 0, 0);      // corner to corner
        send_point(500, 500, 0, 0);
        send_point(500, 500, 0, 0);      // zero length outside
        send_point(-100, 120, 0, 1);
        send_point(420, 120, 0, 0);      // crosses both vertical edges
        send_point(0, 0, 0, 1);
        send_point(640, 1, 0, 0);        // rounding tie upward
        send_point(0, 1, 0, 1);
        send_point(640, 0, 0, 0);        // tie on a falling coordinate
        send_point(640, -1, 0, 0);
        send_point(-8388608, 8388607, 0, 1);
        send_point(8388607, -8388608, 0, 0);
        send_point(-8388608, -8388608, 0, 0);
        send_point(8388607, 8388607, 0, 0);
    endtask

    task automatic test_default_rect();
        random_points(350);
        no_stall = 1'b1;
        random_points(100);
        no_stall = 1'b0;
    endtask

    task automatic test_extreme_rects();
        set_rect(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        random_points(120);
        set_rect(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);   // single point rectangle
        random_points(120);
        set_rect(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        random_points(120);
        set_rect(16'hFFF0, 16'h0010, 16'h0000, 16'h0040);   // zero width
        random_points(100);
    endtask

    task automatic test_random_rects();
        int p;
        for (p = 0; p < 6; p++)
        begin
            set_rect(16'($urandom), 16'($urandom), 16'($urandom_range(0, 700)),
                     16'($urandom_range(0, 700)) | (16'($urandom) & 16'h8000));
            random_points(110);
        end
    endtask

    task automatic test_backpressure();
        set_rect(16'd0, 16'd0, 16'd320, 16'd240);
        hold_req = 1'b1;
        random_points(150);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        gap = 1'b0;
        series_start = 1'b0;
        out_ready = 1'b0;
        err_cnt = 0;
        no_stall = 1'b0;
        hold_req = 1'b0;
        rect_left = 0;
        rect_top = 0;
        rect_w = 320;
        rect_h = 240;
        last_x = 0;
        last_y = 0;
        have_last = 1'b0;
        run_open = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_default_rect();
        test_extreme_rects();
        test_random_rects();
        test_backpressure();

        wait_idle();
        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls per transaction, plus one long hold when asked.
    initial
    begin : receiver
        int n;
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            n = no_stall ? 0 : $urandom_range(0, 8);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (clipped_q.size() == 0)
            begin
                $error("unexpected vertex x=%0d y=%0d", out_x, out_y);
                err_cnt++;
            end
            else
            begin
                want = clipped_q.pop_front();
                if (out_x !== want.x)
                begin
                    $error("out_x expected %0d actual %0d", want.x, out_x);
                    err_cnt++;
                end
                if (out_y !== want.y)
                begin
                    $error("out_y expected %0d actual %0d", want.y, out_y);
                    err_cnt++;
                end
                if (run_begin !== want.rb)
                begin
                    $error("run_begin expected %0d actual %0d", want.rb, run_begin);
                    err_cnt++;
                end
                if (last !== want.lst)
                begin
                    $error("last expected %0d actual %0d", want.lst, last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/core/plrc_pkg.sv
rtl/core/plrc_muldiv.sv
rtl/core/polyline_rect_clipper.sv
tb/tb_top.sv
